// ===== hw/rtl/ops_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ops_pkg
// Shared codes, reset values, sequence lengths and the drive clamp of the
// opponent pursuit sequencer.
// ----------------------------------------------------------------------------
package ops_pkg;

  // Request codes carried with each tick
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_SEARCH = 3'd1;
  localparam logic [2:0] REQ_ATTACK = 3'd2;
  localparam logic [2:0] REQ_BACKOFF = 3'd3;
  localparam logic [2:0] REQ_RAMP_CLR = 3'd4;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ATK_ROT = 3'd1;
  localparam logic [2:0] PH_REV     = 3'd2;
  localparam logic [2:0] PH_STOP    = 3'd3;
  localparam logic [2:0] PH_ROT     = 3'd4;
  localparam logic [2:0] PH_LOOK    = 3'd5;
  localparam logic [2:0] PH_FOUND   = 3'd6;
  localparam logic [2:0] PH_FWD     = 3'd7;

  // LED modes
  localparam logic [1:0] LED_SEARCH  = 2'd0;
  localparam logic [1:0] LED_BACKOFF = 2'd1;
  localparam logic [1:0] LED_ATTACK  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_SEARCH   = 3'd0;
  localparam logic [2:0] REG_BREAKOUT = 3'd1;
  localparam logic [2:0] REG_ROTATE   = 3'd2;
  localparam logic [2:0] REG_STRAIGHT = 3'd3;
  localparam logic [2:0] REG_MAX      = 3'd4;
  localparam logic [2:0] REG_ATTACK   = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_SEARCH   = 8'd80;
  localparam logic [7:0] RST_BREAKOUT = 8'd150;
  localparam logic [7:0] RST_ROTATE   = 8'd120;
  localparam logic [7:0] RST_STRAIGHT = 8'd100;
  localparam logic [7:0] RST_MAX      = 8'd200;
  localparam logic [7:0] RST_ATTACK   = 8'd180;

  // Phase lengths in ticks, stored as length minus one
  localparam logic [7:0] REV_LAST   = 8'd199;
  localparam logic [7:0] STOP_LAST  = 8'd49;
  localparam logic [7:0] ROT_LAST   = 8'd99;
  localparam logic [7:0] LOOK_LAST  = 8'd199;
  localparam logic [7:0] FOUND_LAST = 8'd49;
  localparam logic [7:0] FWD_LAST   = 8'd99;

  // Side rotation gives up once the elapsed count passes this
  localparam logic [7:0] ATK_ROT_LIMIT = 8'd200;
  localparam logic [7:0] TICK_SAT      = 8'd255;

  // Diagonal attack offsets
  localparam logic signed [9:0] DIAG_SLOW = 10'sd30;
  localparam logic signed [9:0] DIAG_FAST = 10'sd10;

  localparam logic signed [9:0] DRV_MAX = 10'sd255;
  localparam logic signed [9:0] DRV_MIN = -10'sd255;

  typedef logic signed [8:0] drive_t;
  typedef logic signed [9:0] wide_drive_t;

  // Saturate a widened drive value to +-255
  function automatic drive_t clamp_drive(input wide_drive_t v);
    drive_t r;
    if (v > DRV_MAX) begin
      r = DRV_MAX[8:0];
    end else if (v < DRV_MIN) begin
      r = DRV_MIN[8:0];
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Zero-extend a speed setting into the widened drive range
  function automatic wide_drive_t widen(input logic [7:0] s);
    return signed'({2'b00, s});
  endfunction

endpackage

// ===== hw/rtl/opponent_pursuit_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opponent_pursuit_sequencer
// Per-tick drive sequencer: search, sensor-priority attack with ram ramp,
// side rotation and the timed backoff sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transfer per millisecond tick, carrying the
//   request code, the four opponent sensor bits and the backoff direction.
//   Result channel (out_*): exactly one transfer per input transfer, in
//   order, with the held left/right drive, the LED mode and busy.
//   Configuration: APB-style port, six 8-bit speed registers at byte
//   addresses 0, 4, ... 20; reads return the stored value, pready is tied
//   high. Write registers only while the block has no tick in flight.
// Timing:
//   An item is captured into the input register on its transfer edge and
//   its result is written into the output register once that register is
//   free, from where it is offered. The sequencer state updates in the
//   same single pass, so one item per cycle is sustained while out_stall
//   stays low; throughput is set by that one combinational step.
// Stall:
//   While the output register holds an untaken result and out_stall is
//   high, the input register holds and in_stall rises once it is full.
// Reset:
//   rst_n low (synchronous) empties both registers, restores the speed
//   defaults and returns the sequencer to idle with zero drive.
// ----------------------------------------------------------------------------
module opponent_pursuit_sequencer
  import ops_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic              in_front_left_seen,
  input  logic              in_front_right_seen,
  input  logic              in_side_left_seen,
  input  logic              in_side_right_seen,
  input  logic              in_turn_dir,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [8:0] out_left_drive,
  output logic signed [8:0] out_right_drive,
  output logic [1:0]        out_led_mode,
  output logic              out_busy_res,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] search_speed_r, breakout_speed_r, rotate_speed_r;
  logic [7:0] straight_speed_r, max_speed_r, attack_speed_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic [7:0] cfg_rd;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_speed_r   <= RST_SEARCH;
      breakout_speed_r <= RST_BREAKOUT;
      rotate_speed_r   <= RST_ROTATE;
      straight_speed_r <= RST_STRAIGHT;
      max_speed_r      <= RST_MAX;
      attack_speed_r   <= RST_ATTACK;
    end else if (cfg_wr) begin
      // Indexes past the register list drop the write
      case (cfg_idx)
        REG_SEARCH:   search_speed_r   <= pwdata[7:0];
        REG_BREAKOUT: breakout_speed_r <= pwdata[7:0];
        REG_ROTATE:   rotate_speed_r   <= pwdata[7:0];
        REG_STRAIGHT: straight_speed_r <= pwdata[7:0];
        REG_MAX:      max_speed_r      <= pwdata[7:0];
        REG_ATTACK:   attack_speed_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEARCH:   cfg_rd = search_speed_r;
      REG_BREAKOUT: cfg_rd = breakout_speed_r;
      REG_ROTATE:   cfg_rd = rotate_speed_r;
      REG_STRAIGHT: cfg_rd = straight_speed_r;
      REG_MAX:      cfg_rd = max_speed_r;
      REG_ATTACK:   cfg_rd = attack_speed_r;
      default:      cfg_rd = 8'd0;
    endcase
  end

  assign prdata = {24'd0, cfg_rd};

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       s1_vld_r;
  logic [2:0] s1_req_r;
  logic       s1_fl_r, s1_fr_r, s1_sl_r, s1_sr_r, s1_dir_r;
  logic       out_vld_r;
  logic       s2_free;

  // The output register can take a new result unless it holds a stalled one
  assign s2_free  = !(out_vld_r && out_stall);
  assign in_stall = s1_vld_r && !s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_req_type;
      s1_fl_r  <= in_front_left_seen;
      s1_fr_r  <= in_front_right_seen;
      s1_sl_r  <= in_side_left_seen;
      s1_sr_r  <= in_side_right_seen;
      s1_dir_r <= in_turn_dir;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  logic [7:0] ramp_count_r, ramp_count_nxt;
  logic       last_seen_dir_r, last_seen_dir_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] phase_ticks_r, phase_ticks_nxt;
  drive_t     left_hold_r, left_hold_nxt;
  drive_t     right_hold_r, right_hold_nxt;
  logic [1:0] led_hold_r, led_hold_nxt;
  logic       turn_hold_r, turn_hold_nxt;

  logic        front, any_seen;
  logic [7:0]  atk_ticks;
  logic [8:0]  ramp_sum;
  wide_drive_t rot_spd, srch_spd, atk_spd, ram_spd;

  assign front    = s1_fl_r && s1_fr_r;
  assign any_seen = s1_fl_r || s1_fr_r || s1_sl_r || s1_sr_r;
  assign ramp_sum = {1'b0, ramp_count_r} + {1'b0, max_speed_r};
  assign rot_spd  = widen(rotate_speed_r);
  assign srch_spd = widen(search_speed_r);
  assign atk_spd  = widen(attack_speed_r);
  assign ram_spd  = signed'({1'b0, ramp_sum});
  assign atk_ticks = (phase_ticks_r < TICK_SAT) ? phase_ticks_r + 8'd1 : phase_ticks_r;

  always_comb begin
    ramp_count_nxt    = ramp_count_r;
    last_seen_dir_nxt = last_seen_dir_r;
    phase_nxt         = phase_r;
    phase_ticks_nxt   = phase_ticks_r;
    left_hold_nxt     = left_hold_r;
    right_hold_nxt    = right_hold_r;
    led_hold_nxt      = led_hold_r;
    turn_hold_nxt     = turn_hold_r;

    if (phase_r != PH_IDLE) begin
      // Busy: every command is dropped, advance the timed sequence
      if (phase_r == PH_ATK_ROT) begin
        phase_ticks_nxt = atk_ticks;
        if (front || atk_ticks > ATK_ROT_LIMIT) begin
          phase_nxt       = PH_IDLE;
          phase_ticks_nxt = 8'd0;
        end
      end else if (phase_r == PH_LOOK && any_seen) begin
        phase_nxt       = PH_FOUND;
        phase_ticks_nxt = FOUND_LAST;
        left_hold_nxt   = '0;
        right_hold_nxt  = '0;
      end else if (phase_ticks_r != 8'd0) begin
        phase_ticks_nxt = phase_ticks_r - 8'd1;
      end else begin
        case (phase_r)
          PH_REV: begin
            phase_nxt       = PH_STOP;
            phase_ticks_nxt = STOP_LAST;
            left_hold_nxt   = '0;
            right_hold_nxt  = '0;
          end
          PH_STOP: begin
            phase_nxt       = PH_ROT;
            phase_ticks_nxt = ROT_LAST;
            if (!turn_hold_r) begin
              left_hold_nxt  = clamp_drive(-rot_spd);
              right_hold_nxt = clamp_drive(rot_spd);
            end else begin
              left_hold_nxt  = clamp_drive(rot_spd);
              right_hold_nxt = clamp_drive(-rot_spd);
            end
          end
          PH_ROT: begin
            // Look keeps the rotation drive
            phase_nxt       = PH_LOOK;
            phase_ticks_nxt = LOOK_LAST;
          end
          PH_LOOK: begin
            phase_nxt       = PH_FWD;
            phase_ticks_nxt = FWD_LAST;
            left_hold_nxt   = clamp_drive(widen(straight_speed_r));
            right_hold_nxt  = clamp_drive(widen(straight_speed_r));
          end
          default: begin
            phase_nxt       = PH_IDLE;
            phase_ticks_nxt = 8'd0;
          end
        endcase
      end
    end else begin
      case (s1_req_r)
        REQ_SEARCH: begin
          led_hold_nxt = LED_SEARCH;
          if (!last_seen_dir_r) begin
            left_hold_nxt  = clamp_drive(-srch_spd);
            right_hold_nxt = clamp_drive(srch_spd);
          end else begin
            left_hold_nxt  = clamp_drive(srch_spd);
            right_hold_nxt = clamp_drive(-srch_spd);
          end
        end
        REQ_ATTACK: begin
          led_hold_nxt = LED_ATTACK;
          if (front && s1_sl_r && s1_sr_r) begin
            left_hold_nxt  = clamp_drive(ram_spd);
            right_hold_nxt = clamp_drive(ram_spd);
            if (ramp_sum < 9'd255) begin
              ramp_count_nxt = ramp_count_r + 8'd1;
            end
          end else if (front) begin
            left_hold_nxt  = clamp_drive(atk_spd);
            right_hold_nxt = clamp_drive(atk_spd);
          end else if (s1_fl_r) begin
            last_seen_dir_nxt = 1'b0;
            left_hold_nxt     = clamp_drive(atk_spd - DIAG_SLOW);
            right_hold_nxt    = clamp_drive(atk_spd + DIAG_FAST);
          end else if (s1_fr_r) begin
            last_seen_dir_nxt = 1'b1;
            left_hold_nxt     = clamp_drive(atk_spd + DIAG_FAST);
            right_hold_nxt    = clamp_drive(atk_spd - DIAG_SLOW);
          end else if (s1_sl_r || s1_sr_r) begin
            // Side-only hit: start a timed rotation toward it
            last_seen_dir_nxt = !s1_sl_r;
            if (s1_sl_r) begin
              left_hold_nxt  = clamp_drive(-rot_spd);
              right_hold_nxt = clamp_drive(rot_spd);
            end else begin
              left_hold_nxt  = clamp_drive(rot_spd);
              right_hold_nxt = clamp_drive(-rot_spd);
            end
            phase_nxt       = PH_ATK_ROT;
            phase_ticks_nxt = 8'd0;
          end
        end
        REQ_BACKOFF: begin
          led_hold_nxt    = LED_BACKOFF;
          turn_hold_nxt   = s1_dir_r;
          phase_nxt       = PH_REV;
          phase_ticks_nxt = REV_LAST;
          left_hold_nxt   = clamp_drive(-widen(breakout_speed_r));
          right_hold_nxt  = clamp_drive(-widen(breakout_speed_r));
        end
        REQ_RAMP_CLR: begin
          ramp_count_nxt = 8'd0;
        end
        default: ;
      endcase
    end
  end

  // Commit state only when an item moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_count_r    <= 8'd0;
      last_seen_dir_r <= 1'b0;
      phase_r         <= PH_IDLE;
      phase_ticks_r   <= 8'd0;
      left_hold_r     <= '0;
      right_hold_r    <= '0;
      led_hold_r      <= LED_SEARCH;
      turn_hold_r     <= 1'b0;
    end else if (s1_vld_r && s2_free) begin
      ramp_count_r    <= ramp_count_nxt;
      last_seen_dir_r <= last_seen_dir_nxt;
      phase_r         <= phase_nxt;
      phase_ticks_r   <= phase_ticks_nxt;
      left_hold_r     <= left_hold_nxt;
      right_hold_r    <= right_hold_nxt;
      led_hold_r      <= led_hold_nxt;
      turn_hold_r     <= turn_hold_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  drive_t     out_left_r, out_right_r;
  logic [1:0] out_led_r;
  logic       out_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s2_free) begin
      out_left_r  <= left_hold_nxt;
      out_right_r <= right_hold_nxt;
      out_led_r   <= led_hold_nxt;
      out_busy_r  <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;
  assign out_led_mode    = out_led_r;
  assign out_busy_res    = out_busy_r;

`ifndef SYNTHESIS
  // Idle always leaves the tick counter cleared
  a_idle_ticks_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (phase_ticks_r == 8'd0))
    else $error("idle phase with nonzero tick count");

  // A side rotation only runs under the attack LED
  a_atk_rot_led: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ATK_ROT) |-> (led_hold_r == LED_ATTACK))
    else $error("side rotation without attack LED");

  // Backoff phases only run under the backoff LED
  a_backoff_led: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE && phase_r != PH_ATK_ROT) |-> (led_hold_r == LED_BACKOFF))
    else $error("backoff phase without backoff LED");

  // Drives never reach the unreachable code -256
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_left_r != 9'sh100 && out_right_r != 9'sh100))
    else $error("drive outside saturation range");

  // A held result keeps its busy flag until taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> (out_vld_r && $stable(out_busy_r)))
    else $error("stalled result changed");
`endif

endmodule
